### hw/rtl/ctsc_pkg.sv
// ----------------------------------------------------------------------------
// ctsc_pkg: shared types and constants of the token scanner
// Token kinds, character classes, scanner states, queue items and keyword
// lookup used by the front, back and result queue of the scanner.
// ----------------------------------------------------------------------------
package ctsc_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 40;
  localparam int TEXT_BYTES_DEF    = 8;
  localparam int NUMBER_WIDTH_DEF  = 32;

  localparam int LEN_W   = 6;
  localparam int TEXT_W  = 64;
  localparam int VALUE_W = 32;
  localparam int LINE_W  = 16;

  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  typedef enum logic [4:0] {
    K_EOF    = 5'd0,
    K_ERR    = 5'd1,
    K_IF     = 5'd2,
    K_ELSE   = 5'd3,
    K_INT    = 5'd4,
    K_RETURN = 5'd5,
    K_VOID   = 5'd6,
    K_WHILE  = 5'd7,
    K_ID     = 5'd8,
    K_NUM    = 5'd9,
    K_PLUS   = 5'd10,
    K_MINUS  = 5'd11,
    K_TIMES  = 5'd12,
    K_OVER   = 5'd13,
    K_LT     = 5'd14,
    K_LE     = 5'd15,
    K_GT     = 5'd16,
    K_GE     = 5'd17,
    K_EQ     = 5'd18,
    K_NE     = 5'd19,
    K_ASSIGN = 5'd20,
    K_SEMI   = 5'd21,
    K_COMMA  = 5'd22,
    K_LPAREN = 5'd23,
    K_RPAREN = 5'd24,
    K_LSQ    = 5'd25,
    K_RSQ    = 5'd26,
    K_LBR    = 5'd27,
    K_RBR    = 5'd28
  } tok_kind_t;

  typedef enum logic [1:0] {
    CC_DIGIT = 2'd0,
    CC_ALPHA = 2'd1,
    CC_SPACE = 2'd2,
    CC_OTHER = 2'd3
  } cclass_t;

  typedef enum logic [9:0] {
    S_START   = 10'b0000000001,
    S_SLASH   = 10'b0000000010,
    S_COMMENT = 10'b0000000100,
    S_CSTAR   = 10'b0000001000,
    S_NUM     = 10'b0000010000,
    S_ID      = 10'b0000100000,
    S_NOT     = 10'b0001000000,
    S_LT      = 10'b0010000000,
    S_GT      = 10'b0100000000,
    S_EQ      = 10'b1000000000
  } scan_state_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = " ";
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_STAR   = "*";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_LT     = "<";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_EQUAL  = "=";
  localparam logic [7:0] CH_BANG   = "!";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LSQ    = "[";
  localparam logic [7:0] CH_RSQ    = "]";
  localparam logic [7:0] CH_LBR    = "{";
  localparam logic [7:0] CH_RBR    = "}";

  // Keyword spellings with the first character in the low byte.
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
  localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;
  localparam logic [47:0] KW_INT    = 48'h0000_0074_6E69;
  localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;
  localparam logic [47:0] KW_VOID   = 48'h0000_6469_6F76;
  localparam logic [47:0] KW_WHILE  = 48'h0065_6C69_6877;

  typedef struct packed {
    logic [7:0] code;
    cclass_t    cls;
    logic       eoi;
  } char_item_t;

  typedef struct packed {
    tok_kind_t            kind;
    logic [TEXT_W-1:0]    text;
    logic [LEN_W-1:0]     length;
    logic [VALUE_W-1:0]   value;
    logic                 overflow;
    logic [LINE_W-1:0]    line;
    logic                 last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } tok_wr_t;

  function automatic cclass_t char_class(input logic [7:0] c);
    cclass_t cls;
    cls = CC_OTHER;
    if (c inside {["0":"9"]}) begin
      cls = CC_DIGIT;
    end else if (c inside {["a":"z"], ["A":"Z"]}) begin
      cls = CC_ALPHA;
    end else if (c == CH_SPACE || c inside {[CH_TAB:CH_CR]}) begin
      cls = CC_SPACE;
    end
    return cls;
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    tok_kind_t k;
    case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_TIMES;
      CH_SEMI:   k = K_SEMI;
      CH_COMMA:  k = K_COMMA;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LSQ:    k = K_LSQ;
      CH_RSQ:    k = K_RSQ;
      CH_LBR:    k = K_LBR;
      CH_RBR:    k = K_RBR;
      default:   k = K_ERR;
    endcase
    return k;
  endfunction

  // Text bytes past the length are always zero, so a full compare is exact.
  function automatic tok_kind_t kw_kind(input logic [47:0] text,
                                        input logic [LEN_W-1:0] len);
    tok_kind_t k;
    k = K_ID;
    if (len == LEN_W'(2) && text == KW_IF) begin
      k = K_IF;
    end else if (len == LEN_W'(4) && text == KW_ELSE) begin
      k = K_ELSE;
    end else if (len == LEN_W'(3) && text == KW_INT) begin
      k = K_INT;
    end else if (len == LEN_W'(6) && text == KW_RETURN) begin
      k = K_RETURN;
    end else if (len == LEN_W'(4) && text == KW_VOID) begin
      k = K_VOID;
    end else if (len == LEN_W'(5) && text == KW_WHILE) begin
      k = K_WHILE;
    end
    return k;
  endfunction

endpackage

### hw/rtl/c_minus_token_scanner.sv
// ----------------------------------------------------------------------------
// c_minus_token_scanner: C-minus lexical scanner
// Turns a stream of source characters into tokens with text, length,
// number value and line.
// ----------------------------------------------------------------------------
// Input channel: one character per transfer on char_code, or an end mark on
// end_of_input. Output channel: one token per transfer, with last_of_run set
// on the final token that a given input transfer produced. A transfer happens
// on a rising edge with valid high and stall low.
// A character is classified on entry and queued; the scanner takes one
// queued character per cycle while the result queue has room, and writes
// zero, one or two tokens into a four-entry result queue. The character that
// finishes a token is registered in the input queue, and the token in the
// result queue, before the token appears on the output.
// Throughput is one character per cycle while the result queue has room;
// characters that produce two tokens are bounded by the one-token-per-cycle
// output, so the scanner waits while fewer than two result slots are free.
// Reset empties both queues, puts the scanner in its start state with an
// empty token and sets the line counter to one. When the receiver stalls,
// the result queue fills, the scanner holds, the two-entry input queue fills
// and in_stall rises; nothing is lost.
// ----------------------------------------------------------------------------
module c_minus_token_scanner
  import ctsc_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int TEXT_BYTES    = TEXT_BYTES_DEF,
  parameter int NUMBER_WIDTH  = NUMBER_WIDTH_DEF
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          char_code,
  input  logic                end_of_input,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [4:0]          token_kind,
  output logic [TEXT_W-1:0]   token_text,
  output logic [LEN_W-1:0]    token_length,
  output logic [VALUE_W-1:0]  number_value,
  output logic                number_overflow,
  output logic [LINE_W-1:0]   line_number,
  output logic                last_of_run
);

  char_item_t item;
  logic       item_valid;
  logic       item_take;
  logic       room;
  tok_wr_t    wr;
  token_t     tok;

  ctsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .item         (item),
    .item_valid   (item_valid),
    .item_take    (item_take)
  );

  ctsc_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .TEXT_BYTES    (TEXT_BYTES),
    .NUMBER_WIDTH  (NUMBER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .room       (room),
    .wr         (wr)
  );

  ctsc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tok       (tok)
  );

  assign token_kind      = tok.kind;
  assign token_text      = tok.text;
  assign token_length    = tok.length;
  assign number_value    = tok.value;
  assign number_overflow = tok.overflow;
  assign line_number     = tok.line;
  assign last_of_run     = tok.last;

endmodule

### hw/rtl/ctsc_front.sv
// ----------------------------------------------------------------------------
// ctsc_front: input acceptance and character classification
// Accepts characters, tags each with its class and holds them in a short
// queue for the scanner.
// ----------------------------------------------------------------------------
module ctsc_front
  import ctsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output char_item_t item,
  output logic       item_valid,
  input  logic       item_take
);

  localparam int PW = $clog2(IQ_DEPTH);

  char_item_t        q [IQ_DEPTH];
  logic [PW-1:0]     wp;
  logic [PW-1:0]     rp;
  logic [PW:0]       cnt;
  logic              push;
  char_item_t        new_item;

  assign in_stall   = (cnt == (PW+1)'(IQ_DEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt != '0);
  assign item       = q[rp];

  always_comb begin
    new_item.code = char_code;
    new_item.cls  = char_class(char_code);
    new_item.eoi  = end_of_input;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + PW'(1);
      end
      if (item_take) begin
        rp <= rp + PW'(1);
      end
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(item_take);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= (PW+1)'(IQ_DEPTH))
    else $error("Input queue count exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst) item_take |-> item_valid)
    else $error("Scanner took a character from an empty input queue.");

endmodule

### hw/rtl/ctsc_back.sv
// ----------------------------------------------------------------------------
// ctsc_back: scanner automaton
// Runs the token automaton on one queued character per cycle while the result
// queue has room, and hands up to two finished tokens to the result queue.
// ----------------------------------------------------------------------------
module ctsc_back
  import ctsc_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
  parameter int TEXT_BYTES    = TEXT_BYTES_DEF,
  parameter int NUMBER_WIDTH  = NUMBER_WIDTH_DEF
)
(
  input  logic       clk,
  input  logic       rst,
  input  char_item_t item,
  input  logic       item_valid,
  output logic       item_take,
  input  logic       room,
  output tok_wr_t    wr
);

  localparam int TW = 8 * TEXT_BYTES;
  localparam logic [NUMBER_WIDTH-1:0] NUM_MAX   = {NUMBER_WIDTH{1'b1}};
  localparam logic [NUMBER_WIDTH-1:0] NUM_TENTH = NUMBER_WIDTH'(NUM_MAX / 10);
  localparam logic [3:0]              NUM_LAST  = 4'(NUM_MAX % 10);
  localparam logic [LEN_W-1:0]        MAX_LEN   = LEN_W'(MAX_TOKEN_LEN);

  scan_state_t             st;
  logic [TW-1:0]           txt;
  logic [LEN_W-1:0]        cnt;
  logic [NUMBER_WIDTH-1:0] acc;
  logic                    sat;
  logic [LINE_W-1:0]       line;

  scan_state_t             st_next;
  logic [TW-1:0]           txt_next;
  logic [LEN_W-1:0]        cnt_next;
  logic [NUMBER_WIDTH-1:0] acc_next;
  logic                    sat_next;
  logic [LINE_W-1:0]       line_next;

  logic [7:0]              c;
  logic [3:0]              dval;
  logic [TW-1:0]           app_txt;
  logic [LEN_W-1:0]        app_cnt;
  logic [TW-1:0]           c_txt;
  logic                    is_eq;
  logic                    again;
  logic                    p_emit;
  tok_kind_t               p_kind;
  logic [TW-1:0]           p_text;
  logic [LEN_W-1:0]        p_len;
  logic                    s_emit;
  tok_kind_t               s_kind;
  logic [TW-1:0]           s_text;
  logic [LEN_W-1:0]        s_len;
  logic [63:0]             acc64;
  token_t                  p_tok;
  token_t                  s_tok;

  assign item_take = item_valid && room;
  assign c         = item.code;
  assign dval      = c[3:0];
  assign is_eq     = (c == CH_EQUAL);
  assign c_txt     = {{(TW-8){1'b0}}, c};
  assign acc64     = 64'(acc);

  always_comb begin
    app_txt = txt;
    app_cnt = cnt;
    if (cnt < MAX_LEN) begin
      app_cnt = cnt + LEN_W'(1);
      for (int i = 0; i < TEXT_BYTES; i++) begin
        if (cnt == LEN_W'(i)) begin
          app_txt[8*i +: 8] = c;
        end
      end
    end
  end

  always_comb begin
    again    = 1'b0;
    p_emit   = 1'b0;
    p_kind   = K_ERR;
    p_text   = txt;
    p_len    = cnt;
    s_emit   = 1'b0;
    s_kind   = K_ERR;
    s_text   = c_txt;
    s_len    = LEN_W'(1);
    st_next  = st;
    txt_next = txt;
    cnt_next = cnt;
    acc_next = acc;
    sat_next = sat;

    if (item.eoi) begin
      case (st)
        S_NUM: begin
          p_emit = 1'b1;
          p_kind = K_NUM;
        end
        S_ID: begin
          p_emit = 1'b1;
          p_kind = kw_kind(txt[47:0], cnt);
        end
        S_SLASH: begin
          p_emit = 1'b1;
          p_kind = K_OVER;
        end
        S_LT: begin
          p_emit = 1'b1;
          p_kind = K_LT;
        end
        S_GT: begin
          p_emit = 1'b1;
          p_kind = K_GT;
        end
        S_EQ: begin
          p_emit = 1'b1;
          p_kind = K_ASSIGN;
        end
        S_NOT: begin
          p_emit = 1'b1;
          p_kind = K_ERR;
        end
        default: begin
        end
      endcase
      s_emit   = 1'b1;
      s_kind   = K_EOF;
      s_text   = '0;
      s_len    = '0;
      st_next  = S_START;
      txt_next = '0;
      cnt_next = '0;
      acc_next = '0;
      sat_next = 1'b0;
    end else begin
      case (st)
        S_START: begin
          again = 1'b1;
        end
        S_SLASH: begin
          if (c == CH_STAR) begin
            st_next  = S_COMMENT;
            txt_next = '0;
            cnt_next = '0;
            acc_next = '0;
            sat_next = 1'b0;
          end else begin
            p_emit = 1'b1;
            p_kind = K_OVER;
            again  = 1'b1;
          end
        end
        S_COMMENT: begin
          if (c == CH_STAR) begin
            st_next = S_CSTAR;
          end
        end
        S_CSTAR: begin
          if (c == CH_SLASH) begin
            st_next = S_START;
          end else if (c != CH_STAR) begin
            st_next = S_COMMENT;
          end
        end
        S_NUM: begin
          if (item.cls == CC_DIGIT) begin
            txt_next = app_txt;
            cnt_next = app_cnt;
            if (acc > NUM_TENTH || (acc == NUM_TENTH && dval > NUM_LAST)) begin
              acc_next = NUM_MAX;
              sat_next = 1'b1;
            end else if (!sat) begin
              acc_next = (acc << 3) + (acc << 1) + NUMBER_WIDTH'(dval);
            end
          end else begin
            p_emit = 1'b1;
            p_kind = K_NUM;
            again  = 1'b1;
          end
        end
        S_ID: begin
          if (item.cls == CC_ALPHA) begin
            txt_next = app_txt;
            cnt_next = app_cnt;
          end else begin
            p_emit = 1'b1;
            p_kind = kw_kind(txt[47:0], cnt);
            again  = 1'b1;
          end
        end
        S_LT, S_GT, S_EQ, S_NOT: begin
          p_emit = 1'b1;
          if (is_eq) begin
            p_text = app_txt;
            p_len  = app_cnt;
          end else begin
            again = 1'b1;
          end
          case (st)
            S_LT:    p_kind = is_eq ? K_LE : K_LT;
            S_GT:    p_kind = is_eq ? K_GE : K_GT;
            S_EQ:    p_kind = is_eq ? K_EQ : K_ASSIGN;
            default: p_kind = is_eq ? K_NE : K_ERR;
          endcase
        end
        default: begin
          again = 1'b1;
        end
      endcase

      if (p_emit || again) begin
        st_next  = S_START;
        txt_next = '0;
        cnt_next = '0;
        acc_next = '0;
        sat_next = 1'b0;
      end

      if (again) begin
        case (item.cls)
          CC_DIGIT: begin
            st_next  = S_NUM;
            txt_next = c_txt;
            cnt_next = LEN_W'(1);
            acc_next = NUMBER_WIDTH'(dval);
          end
          CC_ALPHA: begin
            st_next  = S_ID;
            txt_next = c_txt;
            cnt_next = LEN_W'(1);
          end
          CC_SPACE: begin
          end
          default: begin
            txt_next = c_txt;
            cnt_next = LEN_W'(1);
            case (c)
              CH_LT:    st_next = S_LT;
              CH_GT:    st_next = S_GT;
              CH_EQUAL: st_next = S_EQ;
              CH_BANG:  st_next = S_NOT;
              CH_SLASH: st_next = S_SLASH;
              default: begin
                s_emit   = 1'b1;
                s_kind   = single_kind(c);
                txt_next = '0;
                cnt_next = '0;
              end
            endcase
          end
        endcase
      end
    end
  end

  always_comb begin
    line_next = line;
    if (!item.eoi && c == CH_NL && line != {LINE_W{1'b1}}) begin
      line_next = line + LINE_W'(1);
    end
  end

  always_comb begin
    p_tok.kind     = p_kind;
    p_tok.text     = TEXT_W'(p_text);
    p_tok.length   = p_len;
    p_tok.value    = (p_kind == K_NUM) ? acc64[VALUE_W-1:0] : '0;
    p_tok.overflow = (p_kind == K_NUM) ? sat : 1'b0;
    p_tok.line     = line;
    p_tok.last     = !s_emit;

    s_tok.kind     = s_kind;
    s_tok.text     = TEXT_W'(s_text);
    s_tok.length   = s_len;
    s_tok.value    = '0;
    s_tok.overflow = 1'b0;
    s_tok.line     = line;
    s_tok.last     = 1'b1;

    wr.first  = p_emit ? p_tok : s_tok;
    wr.second = s_tok;
    wr.count  = item_take ? (2'(p_emit) + 2'(s_emit)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_START;
      txt  <= '0;
      cnt  <= '0;
      acc  <= '0;
      sat  <= 1'b0;
      line <= LINE_W'(1);
    end else if (item_take) begin
      st   <= st_next;
      txt  <= txt_next;
      cnt  <= cnt_next;
      acc  <= acc_next;
      sat  <= sat_next;
      line <= line_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      item_take && item.eoi |=> st == S_START && cnt == '0)
    else $error("Scanner did not return to the start state after end of input.");

  assert property (@(posedge clk) disable iff (rst)
      wr.count == 2'd2 |-> wr.second.last && !wr.first.last)
    else $error("Last-of-run marking is wrong on a two-token transfer.");

endmodule

### hw/rtl/ctsc_outq.sv
// ----------------------------------------------------------------------------
// ctsc_outq: result token queue
// Holds finished tokens, takes up to two per cycle from the scanner and
// presents one per transfer on the output channel.
// ----------------------------------------------------------------------------
module ctsc_outq
  import ctsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  tok_wr_t wr,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output token_t  tok
);

  localparam int PW = $clog2(OQ_DEPTH);

  token_t          q [OQ_DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [PW:0]     cnt;
  logic            pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt <= (PW+1)'(OQ_DEPTH - 2));
  assign tok       = q[rp];

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      q[wp] <= wr.first;
    end
    if (wr.count == 2'd2) begin
      q[wp + PW'(1)] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp <= wp + PW'(wr.count);
      if (pop) begin
        rp <= rp + PW'(1);
      end
      cnt <= cnt + (PW+1)'(wr.count) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= (PW+1)'(OQ_DEPTH))
    else $error("Result queue count exceeds its depth.");

  assert property (@(posedge clk) disable iff (rst) wr.count != 2'd0 |-> room)
    else $error("Scanner wrote tokens without room in the result queue.");

endmodule
